// ----- sv/i2cee_pkg.sv -----
// Shared widths, command codes and constants for the I2C EEPROM access master.
// No dependencies; imported by the channel interfaces, the top level and the checker.
package i2cee_pkg;

  localparam int unsigned ADDR_W        = 11;
  localparam int unsigned ADDR_BITS_DEF = 11;
  localparam int unsigned DATA_W        = 8;
  localparam int unsigned CMD_W         = 2;

  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd2;

  localparam logic [DATA_W-1:0] TIMEOUT_RST = 8'd10;
  localparam logic [DATA_W-1:0] DEV_WR      = 8'hA0;
  localparam logic [DATA_W-1:0] DEV_RD      = 8'hA1;

endpackage

// ----- sv/i2cee_in_if.sv -----
// Input channel: one bus phase item (command, address, data, sampled line, ms tick).
// Depends on i2cee_pkg.
interface i2cee_in_if import i2cee_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [ADDR_W-1:0] address;
  logic [DATA_W-1:0] write_data;
  logic              sda_in;
  logic              ms_tick;

  modport source (output valid, command, address, write_data, sda_in, ms_tick, input ready);
  modport sink   (input valid, command, address, write_data, sda_in, ms_tick, output ready);
endinterface

// ----- sv/i2cee_out_if.sv -----
// Result channel: bus levels and access status for one phase item.
// Depends on i2cee_pkg.
interface i2cee_out_if import i2cee_pkg::*;;
  logic              valid;
  logic              ready;
  logic              scl_level;
  logic              sda_level;
  logic              busy_res;
  logic              done_res;
  logic [DATA_W-1:0] read_data;
  logic              timed_out;

  modport source (output valid, scl_level, sda_level, busy_res, done_res, read_data,
                  timed_out, input ready);
  modport sink   (input valid, scl_level, sda_level, busy_res, done_res, read_data,
                  timed_out, output ready);
endinterface

// ----- sv/i2c_eeprom_access_master.sv -----
// I2C master for 24C01..24C16 EEPROMs, one bus phase per item: phase sequencer and result register.
// Depends on i2cee_pkg, i2cee_in_if, i2cee_out_if.
//
// Usage: in_ch carries one item per bus phase. In idle, command READ or WRITE
// starts an access at address; the same item already produces the first
// start phase. While an access runs, every other item is a tick that advances
// one phase; in idle it does nothing. Each item yields exactly one result on
// out_ch: scl/sda levels to put on the bus for that phase, busy, a one-item
// done pulse, the last byte read and the timeout flag of a write poll.
// Result: registered, valid in the cycle after the item is accepted.
// Throughput: one item per cycle while out_ch.ready is high; the sequencer next state
// and the result are computed in one pass and written to the state and result registers.
// Stall: the result register holds while out_ch.ready is low; in_ch.ready is
// low only while a result is held, so one item is in flight at most.
// Reset (rst_n low, synchronous): sequencer idle, all state zero, no result
// pending, poll timeout register back to 10 ms.
// cfg_we/cfg_wdata write the poll timeout (ms); write only while idle.
module i2c_eeprom_access_master import i2cee_pkg::*; #(
  parameter int unsigned ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  i2cee_in_if.sink          in_ch,
  i2cee_out_if.source       out_ch,
  input  logic              cfg_we,
  input  logic [DATA_W-1:0] cfg_wdata
);

  typedef enum logic [4:0] {
    PH_IDLE    = 5'd0,
    PH_SW      = 5'd1,
    PH_SR      = 5'd2,
    PH_SP      = 5'd3,
    PH_STRD    = 5'd4,
    PH_STWR    = 5'd5,
    PH_STOK    = 5'd6,
    PH_STTO    = 5'd7,
    PH_DEVW_LO = 5'd8,
    PH_DEVW_HI = 5'd9,
    PH_WORD_LO = 5'd10,
    PH_WORD_HI = 5'd11,
    PH_DATA_LO = 5'd12,
    PH_DATA_HI = 5'd13,
    PH_DEVR_LO = 5'd14,
    PH_DEVR_HI = 5'd15,
    PH_RX_LO   = 5'd16,
    PH_RX_HI   = 5'd17,
    PH_POLL_LO = 5'd18,
    PH_POLL_HI = 5'd19
  } phase_t;

  localparam logic [2:0] BY_DEVW = 3'd0;
  localparam logic [2:0] BY_WORD = 3'd1;
  localparam logic [2:0] BY_DATA = 3'd2;
  localparam logic [2:0] BY_DEVR = 3'd3;
  localparam logic [2:0] BY_RX   = 3'd4;

  phase_t                phase_r, phase_nxt, ph;
  logic [3:0]            bc_r, bc_nxt, bc;
  logic [DATA_W-1:0]     sr_r, sr_nxt;
  logic [ADDR_BITS-1:0]  addr_r, addr_nxt;
  logic [DATA_W-1:0]     data_r, data_nxt;
  logic                  wr_r, wr_nxt;
  logic [DATA_W-1:0]     pt_r, pt_nxt;
  logic [DATA_W-1:0]     lr_r, lr_nxt;
  logic [DATA_W-1:0]     tmo_cfg_r;

  logic                  start;
  logic [4:0]            ph_code;
  logic [2:0]            which;
  logic                  rx;
  logic [ADDR_W-1:0]     addr_ext;
  logic [DATA_W-1:0]     dev;
  logic                  scl, sda, done, tmo;

  logic                  out_valid_r;
  logic                  scl_r, sda_r, busy_r, done_r, tmo_r;
  logic [DATA_W-1:0]     rd_r;
  logic                  accept;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    start    = (phase_r == PH_IDLE) &&
               (in_ch.command == CMD_READ || in_ch.command == CMD_WRITE);
    ph       = start ? PH_SW : phase_r;
    bc       = start ? 4'd0 : bc_r;
    addr_nxt = start ? in_ch.address[ADDR_BITS-1:0] : addr_r;
    data_nxt = start ? in_ch.write_data : data_r;
    wr_nxt   = start ? (in_ch.command == CMD_WRITE) : wr_r;
    addr_ext = ADDR_W'(addr_nxt);
    dev      = {4'b0000, addr_ext[10:8], 1'b0};
    ph_code  = ph;
    which    = 3'(ph_code[4:1] - 4'd4);
    rx       = (which == BY_RX);

    phase_nxt = ph;
    bc_nxt    = bc;
    sr_nxt    = sr_r;
    pt_nxt    = pt_r;
    lr_nxt    = lr_r;
    scl       = 1'b1;
    sda       = 1'b1;
    done      = 1'b0;
    tmo       = 1'b0;

    if ((ph == PH_SP || ph == PH_POLL_LO || ph == PH_POLL_HI) && in_ch.ms_tick &&
        pt_r != 8'hFF) begin
      pt_nxt = pt_r + 8'd1;
    end

    unique case (ph)
      PH_SW, PH_SR, PH_SP: begin
        scl    = (bc != 4'd0);
        sda    = (bc < 4'd2);
        bc_nxt = bc + 4'd1;
        if (bc >= 4'd2) begin
          bc_nxt = 4'd0;
          if (ph == PH_SW) begin
            phase_nxt = PH_DEVW_LO;
            sr_nxt    = DEV_WR | dev;
          end else if (ph == PH_SR) begin
            phase_nxt = PH_DEVR_LO;
            sr_nxt    = DEV_RD | dev;
          end else begin
            phase_nxt = PH_POLL_LO;
            sr_nxt    = DEV_WR | dev;
          end
        end
      end
      PH_STRD, PH_STWR, PH_STOK, PH_STTO: begin
        scl    = (bc != 4'd0);
        sda    = (bc >= 4'd2);
        bc_nxt = bc + 4'd1;
        if (bc >= 4'd2) begin
          bc_nxt = 4'd0;
          if (ph == PH_STWR) begin
            phase_nxt = PH_SP;
            pt_nxt    = '0;
          end else begin
            phase_nxt = PH_IDLE;
            done      = 1'b1;
            tmo       = (ph == PH_STTO);
          end
        end
      end
      PH_DEVW_LO, PH_DEVW_HI, PH_WORD_LO, PH_WORD_HI, PH_DATA_LO, PH_DATA_HI,
      PH_DEVR_LO, PH_DEVR_HI, PH_RX_LO, PH_RX_HI, PH_POLL_LO, PH_POLL_HI: begin
        scl = ph_code[0];
        sda = (bc < 4'd8 && !rx) ? sr_r[7] : 1'b1;
        if (!ph_code[0]) begin
          phase_nxt = phase_t'(ph_code + 5'd1);
        end else if (bc < 4'd8) begin
          sr_nxt    = {sr_r[6:0], rx ? in_ch.sda_in : 1'b0};
          bc_nxt    = bc + 4'd1;
          if (rx && bc == 4'd7) begin
            lr_nxt = {sr_r[6:0], in_ch.sda_in};
          end
          phase_nxt = phase_t'(ph_code - 5'd1);
        end else begin
          bc_nxt = 4'd0;
          unique case (which)
            BY_DEVW: begin
              phase_nxt = PH_WORD_LO;
              sr_nxt    = addr_ext[7:0];
            end
            BY_WORD: begin
              if (wr_nxt) begin
                phase_nxt = PH_DATA_LO;
                sr_nxt    = data_nxt;
              end else begin
                phase_nxt = PH_SR;
              end
            end
            BY_DATA: phase_nxt = PH_STWR;
            BY_DEVR: begin
              phase_nxt = PH_RX_LO;
              sr_nxt    = '0;
            end
            BY_RX:   phase_nxt = PH_STRD;
            default: begin
              if (!in_ch.sda_in) begin
                phase_nxt = PH_STOK;
              end else if (pt_nxt > tmo_cfg_r) begin
                phase_nxt = PH_STTO;
              end else begin
                phase_nxt = PH_SP;
              end
            end
          endcase
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        bc_nxt    = 4'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tmo_cfg_r <= TIMEOUT_RST;
    end else if (cfg_we) begin
      tmo_cfg_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      bc_r        <= '0;
      sr_r        <= '0;
      addr_r      <= '0;
      data_r      <= '0;
      wr_r        <= 1'b0;
      pt_r        <= '0;
      lr_r        <= '0;
      out_valid_r <= 1'b0;
    end else if (accept) begin
      phase_r     <= phase_nxt;
      bc_r        <= bc_nxt;
      sr_r        <= sr_nxt;
      addr_r      <= addr_nxt;
      data_r      <= data_nxt;
      wr_r        <= wr_nxt;
      pt_r        <= pt_nxt;
      lr_r        <= lr_nxt;
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      scl_r  <= scl;
      sda_r  <= sda;
      busy_r <= (phase_nxt != PH_IDLE);
      done_r <= done;
      tmo_r  <= tmo;
      rd_r   <= lr_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.scl_level = scl_r;
  assign out_ch.sda_level = sda_r;
  assign out_ch.busy_res  = busy_r;
  assign out_ch.done_res  = done_r;
  assign out_ch.read_data = rd_r;
  assign out_ch.timed_out = tmo_r;

endmodule

// ----- sv/i2cee_checker.sv -----
// Port-level checks for i2c_eeprom_access_master, attached by bind.
// Depends on i2cee_pkg and the top level's channel interfaces.
module i2cee_checker import i2cee_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_scl,
  input logic              out_sda,
  input logic              out_busy,
  input logic              out_done,
  input logic [DATA_W-1:0] out_rd,
  input logic              out_tmo
);

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_scl) && $stable(out_sda) &&
    $stable(out_busy) && $stable(out_done) && $stable(out_rd) && $stable(out_tmo))
    else $error("held result changed");

  a_item_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted item produced no result");

  a_ready_only_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without held result");

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done |-> !out_busy)
    else $error("done while busy");

  a_tmo_with_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_tmo |-> out_done)
    else $error("timeout flag without done");

endmodule

bind i2c_eeprom_access_master i2cee_checker u_i2cee_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_scl   (out_ch.scl_level),
  .out_sda   (out_ch.sda_level),
  .out_busy  (out_ch.busy_res),
  .out_done  (out_ch.done_res),
  .out_rd    (out_ch.read_data),
  .out_tmo   (out_ch.timed_out)
);
